// ===== src/grw_pkg.sv =====
// shared types, constants and helper functions of the grid random walk visit counter
`default_nettype none

package grw_pkg;

	// grid limits and widths
	localparam int MAX_X      = 64;
	localparam int MAX_Y      = 64;
	localparam int COUNT_W    = 32;
	localparam int X_W        = 6;
	localparam int Y_W        = 6;
	localparam int DIM_W      = 7;
	localparam int ADDR_W     = X_W + Y_W;
	localparam int DEPTH      = MAX_X * MAX_Y;
	localparam int AREA_W     = 2 * DIM_W;
	localparam int VISITED_W  = 13;
	localparam int CLR_W      = ADDR_W + 1;

	// register reset values
	localparam logic [DIM_W-1:0] RESET_GRID  = 7'd20;
	localparam logic [X_W-1:0]   RESET_START = 6'd10;

	// register indexes on the configuration channel
	localparam logic [1:0] CFG_GRID_WIDTH  = 2'd0;
	localparam logic [1:0] CFG_GRID_HEIGHT = 2'd1;
	localparam logic [1:0] CFG_START_X     = 2'd2;
	localparam logic [1:0] CFG_START_Y     = 2'd3;

	// move tables indexed by direction: 0 +y,1 +x+y,2 +x,3 +x-y,4 -y,5 -x-y,6 -x,7 -x+y
	localparam logic [7:0] DX_POS = 8'b0000_1110;
	localparam logic [7:0] DX_NEG = 8'b1110_0000;
	localparam logic [7:0] DY_POS = 8'b1000_0011;
	localparam logic [7:0] DY_NEG = 8'b0011_1000;

	typedef enum logic {
		OP_STEP = 1'b0,
		OP_READ = 1'b1
	} op_t;

	// one item on its way from the walker stage to the count stage
	typedef struct packed {
		logic               init;
		op_t                op;
		logic               in_grid;
		logic [X_W-1:0]     x;
		logic [Y_W-1:0]     y;
		logic [ADDR_W-1:0]  addr;
		logic [COUNT_W-1:0] total;
	} walk_pkt_t;

	// one result beat
	typedef struct packed {
		logic               all_visited;
		logic [COUNT_W-1:0] total_steps;
		logic [COUNT_W-1:0] cell_count;
		logic [Y_W-1:0]     pos_y;
		logic [X_W-1:0]     pos_x;
	} result_t;

	// register value to usable grid size
	function automatic logic [DIM_W-1:0] eff_size(input logic [DIM_W-1:0] v,
			input logic [DIM_W-1:0] max_v);
		logic [DIM_W-1:0] r;
		r = v;
		if (v == '0) begin
			r = DIM_W'(1);
		end else if (v > max_v) begin
			r = max_v;
		end
		return r;
	endfunction

	// keep a coordinate inside the grid
	function automatic logic [X_W-1:0] clamp_pos(input logic [X_W-1:0] p,
			input logic [DIM_W-1:0] lim);
		logic [DIM_W-1:0] lm1;
		lm1 = lim - DIM_W'(1);
		return ({1'b0, p} >= lim) ? lm1[X_W-1:0] : p;
	endfunction

	// one axis move, held at the grid edges
	function automatic logic [X_W-1:0] axis_move(input logic [X_W-1:0] p, input logic up,
			input logic down, input logic [DIM_W-1:0] lim);
		logic [DIM_W-1:0] nx;
		logic [X_W-1:0]   r;
		nx = {1'b0, p} + DIM_W'(1);
		r  = p;
		if (up && (nx < lim)) begin
			r = nx[X_W-1:0];
		end else if (down && (p != '0)) begin
			r = p - X_W'(1);
		end
		return r;
	endfunction

	// saturating increment of a count
	function automatic logic [COUNT_W-1:0] sat_inc(input logic [COUNT_W-1:0] v);
		return (v == '1) ? v : v + COUNT_W'(1);
	endfunction

endpackage

`default_nettype wire

// ===== src/grid_random_walk_visit_counter_top.sv =====
// top level: config registers, stream ports, walker and count stages
// an accepted input beat is registered in the count stage, then in the result register
// throughput: one item per cycle unless results stall, set by the visit store RMW with forwarding
// the first item after reset waits while the start cell is recorded
// reset: a clear sweep writes all 4096 store entries, one per cycle, before input is taken
// config writes are accepted during the sweep
`default_nettype none

module grid_random_walk_visit_counter_top import grw_pkg::*; (
	input  wire logic        clk,
	input  wire logic        arst_n,
	// config write channel
	input  wire logic        cfg_valid,
	output logic             cfg_ready,
	input  wire logic [1:0]  cfg_index,
	input  wire logic [6:0]  cfg_data,
	// input stream
	input  wire logic        s_axis_tvalid,
	output logic             s_axis_tready,
	input  wire logic [15:0] s_axis_tdata,  // direction[2:0], read_x[8:3], read_y[14:9], zero
	input  wire logic        s_axis_tuser,  // op
	// result stream
	output logic             m_axis_tvalid,
	input  wire logic        m_axis_tready,
	output logic [79:0]      m_axis_tdata   // pos_x, pos_y, cell_count, total_steps,
	                                        // all_visited, zero (from bit 0 up)
);

	logic [DIM_W-1:0] grid_width_q;
	logic [DIM_W-1:0] grid_height_q;
	logic [X_W-1:0]   start_x_q;
	logic [Y_W-1:0]   start_y_q;
	logic [DIM_W-1:0] grid_w;
	logic [DIM_W-1:0] grid_h;
	logic             started;
	logic             s1_free;
	logic             clearing;
	logic             accept;
	logic             init_go;
	walk_pkt_t        pkt;
	result_t          res;

	assign cfg_ready = 1'b1;

	// config registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			grid_width_q  <= RESET_GRID;
			grid_height_q <= RESET_GRID;
			start_x_q     <= RESET_START;
			start_y_q     <= RESET_START;
		end else if (cfg_valid) begin
			case (cfg_index)
				CFG_GRID_WIDTH:  grid_width_q  <= cfg_data;
				CFG_GRID_HEIGHT: grid_height_q <= cfg_data;
				CFG_START_X:     start_x_q     <= cfg_data[X_W-1:0];
				CFG_START_Y:     start_y_q     <= cfg_data[Y_W-1:0];
				default: ;
			endcase
		end
	end

	assign grid_w = eff_size(grid_width_q, DIM_W'(MAX_X));
	assign grid_h = eff_size(grid_height_q, DIM_W'(MAX_Y));

	// handshake: the first item waits while the start cell is recorded
	assign s_axis_tready = s1_free && started && !clearing;
	assign accept        = s_axis_tvalid && s_axis_tready;
	assign init_go       = s_axis_tvalid && !started && !clearing && s1_free;

	grw_walk u_walk (
		.clk      (clk),
		.arst_n   (arst_n),
		.accept   (accept),
		.init_go  (init_go),
		.op       (op_t'(s_axis_tuser)),
		.direction(s_axis_tdata[2:0]),
		.read_x   (s_axis_tdata[8:3]),
		.read_y   (s_axis_tdata[14:9]),
		.grid_w   (grid_w),
		.grid_h   (grid_h),
		.start_x  (start_x_q),
		.start_y  (start_y_q),
		.started  (started),
		.pkt      (pkt)
	);

	grw_count u_count (
		.clk      (clk),
		.arst_n   (arst_n),
		.pkt_valid(accept || init_go),
		.pkt      (pkt),
		.grid_w   (grid_w),
		.grid_h   (grid_h),
		.s1_free  (s1_free),
		.clearing (clearing),
		.res_valid(m_axis_tvalid),
		.res_ready(m_axis_tready),
		.res      (res)
	);

	assign m_axis_tdata = {3'b000, res};

	// no item is taken before the clear sweep is done and the start is recorded
	a_no_accept_early: assert property (@(posedge clk) disable iff (!arst_n)
		accept |-> (!clearing && started))
		else $error("item accepted during clear sweep or before start");

	// step total in a result is never zero
	a_total_nonzero: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid |-> (m_axis_tdata[75:44] != '0))
		else $error("zero step total in result");

	// reported walker position lies inside the grid
	a_pos_in_grid: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid |-> (({1'b0, m_axis_tdata[5:0]} < grid_w) &&
			({1'b0, m_axis_tdata[11:6]} < grid_h)))
		else $error("walker position outside grid");

	// once the start cell is recorded it is marked as started, so it is recorded only once after reset
	a_init_once: assert property (@(posedge clk) disable iff (!arst_n)
		init_go |=> started)
		else $error("start cell not marked as recorded");

endmodule

`default_nettype wire

// ===== src/grw_ram.sv =====
// generic single-port-write, single-port-read ram with registered read
`default_nettype none

module grw_ram #(
	parameter int WIDTH = 32,
	parameter int DEPTH = 4096
) (
	input  wire logic                     clk,
	input  wire logic                     wr_en,
	input  wire logic [$clog2(DEPTH)-1:0] wr_addr,
	input  wire logic [WIDTH-1:0]         wr_data,
	input  wire logic [$clog2(DEPTH)-1:0] rd_addr,
	output logic      [WIDTH-1:0]         rd_data
);

	logic [WIDTH-1:0] mem [DEPTH];

	// write and registered read
	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem[wr_addr] <= wr_data;
		end
		rd_data <= mem[rd_addr];
	end

endmodule

`default_nettype wire

// ===== src/grw_walk.sv =====
// walker stage: position update, clamping, step total and start load
`default_nettype none

module grw_walk import grw_pkg::*; (
	input  wire logic             clk,
	input  wire logic             arst_n,
	input  wire logic             accept,
	input  wire logic             init_go,
	input  wire op_t              op,
	input  wire logic [2:0]       direction,
	input  wire logic [X_W-1:0]   read_x,
	input  wire logic [Y_W-1:0]   read_y,
	input  wire logic [DIM_W-1:0] grid_w,
	input  wire logic [DIM_W-1:0] grid_h,
	input  wire logic [X_W-1:0]   start_x,
	input  wire logic [Y_W-1:0]   start_y,
	output logic                  started,
	output walk_pkt_t             pkt
);

	logic [X_W-1:0]     walker_x_q;
	logic [Y_W-1:0]     walker_y_q;
	logic               started_q;
	logic [COUNT_W-1:0] total_q;
	logic [X_W-1:0]     cur_x;
	logic [Y_W-1:0]     cur_y;
	logic [X_W-1:0]     st_x;
	logic [Y_W-1:0]     st_y;
	logic [X_W-1:0]     nx;
	logic [Y_W-1:0]     ny;

	assign started = started_q;

	// clamp the walker and the start cell into the current grid, then move on a step op
	always_comb begin
		st_x  = clamp_pos(start_x, grid_w);
		st_y  = clamp_pos(start_y, grid_h);
		cur_x = clamp_pos(walker_x_q, grid_w);
		cur_y = clamp_pos(walker_y_q, grid_h);
		nx    = cur_x;
		ny    = cur_y;
		if (op == OP_STEP) begin
			nx = axis_move(cur_x, DX_POS[direction], DX_NEG[direction], grid_w);
			ny = axis_move(cur_y, DY_POS[direction], DY_NEG[direction], grid_h);
		end
	end

	// packet for the count stage
	always_comb begin
		pkt.init    = init_go;
		pkt.op      = op;
		pkt.in_grid = ({1'b0, read_x} < grid_w) && ({1'b0, read_y} < grid_h);
		pkt.x       = nx;
		pkt.y       = ny;
		pkt.total   = (op == OP_STEP) ? sat_inc(total_q) : total_q;
		if (init_go) begin
			pkt.x     = st_x;
			pkt.y     = st_y;
			pkt.op    = OP_STEP;
			pkt.total = total_q;
		end
		if (!init_go && (op == OP_READ)) begin
			pkt.addr = {read_x, read_y};
		end else begin
			pkt.addr = {pkt.x, pkt.y};
		end
	end

	// walker registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			walker_x_q <= '0;
			walker_y_q <= '0;
			started_q  <= 1'b0;
			total_q    <= COUNT_W'(1);
		end else if (init_go) begin
			walker_x_q <= st_x;
			walker_y_q <= st_y;
			started_q  <= 1'b1;
		end else if (accept) begin
			walker_x_q <= nx;
			walker_y_q <= ny;
			total_q    <= pkt.total;
		end
	end

endmodule

`default_nettype wire

// ===== src/grw_count.sv =====
// count stage: visit store read-modify-write, forwarding, clear sweep, result register
`default_nettype none

module grw_count import grw_pkg::*; (
	input  wire logic             clk,
	input  wire logic             arst_n,
	input  wire logic             pkt_valid,
	input  wire walk_pkt_t        pkt,
	input  wire logic [DIM_W-1:0] grid_w,
	input  wire logic [DIM_W-1:0] grid_h,
	output logic                  s1_free,
	output logic                  clearing,
	output logic                  res_valid,
	input  wire logic             res_ready,
	output result_t               res
);

	logic               valid_s1;
	walk_pkt_t          pkt_s1;
	logic               s1_done;
	logic               s1_hold;
	logic [CLR_W-1:0]   clr_q;
	logic [VISITED_W-1:0] visited_q;
	logic [VISITED_W-1:0] visited_nx;
	logic               fwd_valid_q;
	logic [ADDR_W-1:0]  fwd_addr_q;
	logic [COUNT_W-1:0] fwd_data_q;
	logic               wr_en;
	logic [ADDR_W-1:0]  wr_addr;
	logic [COUNT_W-1:0] wr_data;
	logic [ADDR_W-1:0]  rd_addr;
	logic [COUNT_W-1:0] rd_data;
	logic [COUNT_W-1:0] cur_cnt;
	logic [COUNT_W-1:0] new_cnt;
	logic [AREA_W-1:0]  area;
	logic               out_valid_q;
	result_t            out_q;
	result_t            res_nx;

	assign clearing  = !clr_q[CLR_W-1];
	assign res_valid = out_valid_q;
	assign res       = out_q;

	// stage advance: init ops retire without a result beat
	assign s1_done = valid_s1 && (pkt_s1.init || !out_valid_q || res_ready);
	assign s1_free = !valid_s1 || s1_done;
	assign s1_hold = valid_s1 && !s1_done;

	// a held item reads its entry again so the ram output stays current
	assign rd_addr = s1_hold ? pkt_s1.addr : pkt.addr;

	// write issued at the same edge as the read is forwarded
	assign cur_cnt = (fwd_valid_q && (fwd_addr_q == pkt_s1.addr)) ? fwd_data_q : rd_data;
	assign new_cnt = pkt_s1.init ? COUNT_W'(1) : sat_inc(cur_cnt);

	// write port: clear sweep after reset, else step write-back
	always_comb begin
		if (clearing) begin
			wr_en   = 1'b1;
			wr_addr = clr_q[ADDR_W-1:0];
			wr_data = '0;
		end else begin
			wr_en   = s1_done && (pkt_s1.op == OP_STEP);
			wr_addr = pkt_s1.addr;
			wr_data = new_cnt;
		end
	end

	grw_ram #(
		.WIDTH(COUNT_W),
		.DEPTH(DEPTH)
	) u_store (
		.clk    (clk),
		.wr_en  (wr_en),
		.wr_addr(wr_addr),
		.wr_data(wr_data),
		.rd_addr(rd_addr),
		.rd_data(rd_data)
	);

	// distinct-cell count and result assembly
	always_comb begin
		area       = AREA_W'(grid_w) * AREA_W'(grid_h);
		visited_nx = visited_q;
		if (!pkt_s1.init && (pkt_s1.op == OP_STEP) && (cur_cnt == '0)) begin
			visited_nx = visited_q + VISITED_W'(1);
		end
		res_nx.pos_x       = pkt_s1.x;
		res_nx.pos_y       = pkt_s1.y;
		res_nx.total_steps = pkt_s1.total;
		res_nx.all_visited = (AREA_W'(visited_nx) >= area);
		if (pkt_s1.op == OP_STEP) begin
			res_nx.cell_count = new_cnt;
		end else if (pkt_s1.in_grid) begin
			res_nx.cell_count = cur_cnt;
		end else begin
			res_nx.cell_count = '0;
		end
	end

	// control registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1    <= 1'b0;
			clr_q       <= '0;
			visited_q   <= VISITED_W'(1);
			fwd_valid_q <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			if (clearing) begin
				clr_q <= clr_q + CLR_W'(1);
			end
			if (s1_free) begin
				valid_s1 <= pkt_valid;
			end
			if (s1_done) begin
				visited_q <= visited_nx;
			end
			fwd_valid_q <= wr_en && !clearing;
			if (s1_done && !pkt_s1.init) begin
				out_valid_q <= 1'b1;
			end else if (res_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	// payload registers
	always_ff @(posedge clk) begin
		if (s1_free && pkt_valid) begin
			pkt_s1 <= pkt;
		end
		fwd_addr_q <= wr_addr;
		fwd_data_q <= wr_data;
		if (s1_done && !pkt_s1.init) begin
			out_q <= res_nx;
		end
	end

endmodule

`default_nettype wire
